### rtl/core/cmgp_pkg.sv
`default_nettype none

package cmgp_pkg;

  localparam int SAMPLE_BITS_DEF = 32;
  localparam int FIELD_W = 32;
  localparam int GRAY_W = 8;
  localparam int LEVEL_IDX_W = 3;
  localparam int MULT_W = 18;

  // 260100 = 2^18 - 2^11 + 2^2 and 510 = 2^9 - 2^1.
  localparam int AMP_SH_A = 18;
  localparam int AMP_SH_B = 11;
  localparam int AMP_SH_C = 2;
  localparam int INT_SH_A = 9;
  localparam int INT_SH_B = 1;

  typedef enum logic {
    KIND_AMPLITUDE = 1'b0,
    KIND_INTENSITY = 1'b1
  } cmgp_kind_t;

  typedef enum logic {
    MODE_MEASURE = 1'b0,
    MODE_RENDER  = 1'b1
  } cmgp_mode_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SQ_RE,
    S_SQ_IM,
    S_SUM,
    S_PEAK,
    S_RHS,
    S_T_SQ,
    S_T_MLO,
    S_T_MHI,
    S_T_CMP,
    S_DONE
  } cmgp_state_t;

  typedef struct packed {
    logic capture;
    logic sq_re;
    logic sq_im;
    logic sum;
    logic peak_upd;
    logic rhs;
    logic trial_sq;
    logic trial_mlo;
    logic trial_mhi;
    logic trial_cmp;
    logic load_out;
  } cmgp_cmd_t;

  typedef struct packed {
    logic render;
    logic peak_zero;
    logic last_step;
  } cmgp_status_t;

endpackage

`default_nettype wire

### rtl/core/cmgp_dp.sv
`default_nettype none

module cmgp_dp #(
  parameter int SAMPLE_BITS = cmgp_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_write,
  input  wire logic                             cfg_preview_kind,
  input  wire logic                             in_mode,
  input  wire logic                             in_first,
  input  wire logic signed [cmgp_pkg::FIELD_W-1:0] in_real_part,
  input  wire logic signed [cmgp_pkg::FIELD_W-1:0] in_imag_part,
  input  wire cmgp_pkg::cmgp_cmd_t              cmd,
  output cmgp_pkg::cmgp_status_t                status,
  output logic [cmgp_pkg::GRAY_W-1:0]           out_gray
);
  import cmgp_pkg::*;

  localparam int EW = 2 * SAMPLE_BITS;
  localparam int PW = EW + MULT_W;
  localparam int HW = SAMPLE_BITS + MULT_W;

  logic [SAMPLE_BITS-1:0] re_raw, im_raw, re_abs, im_abs;
  logic [SAMPLE_BITS-1:0] re_r, im_r;
  logic                   mode_r, first_r;
  logic [EW-1:0]          sq_re_r, sq_im_r, energy_r, peak_r;
  logic [PW-1:0]          rhs_r, energy_w, lhs;
  logic [MULT_W-1:0]      m_r;
  logic [HW-1:0]          plo_r, phi_r;
  logic [GRAY_W-1:0]      g_r, trial, gray_r;
  logic [GRAY_W:0]        odd;
  logic [LEVEL_IDX_W-1:0] idx_r;
  cmgp_kind_t             kind_r;

  assign re_raw = in_real_part[SAMPLE_BITS-1:0];
  assign im_raw = in_imag_part[SAMPLE_BITS-1:0];
  assign re_abs = re_raw[SAMPLE_BITS-1] ? SAMPLE_BITS'(~re_raw + 1'b1) : re_raw;
  assign im_abs = im_raw[SAMPLE_BITS-1] ? SAMPLE_BITS'(~im_raw + 1'b1) : im_raw;

  assign energy_w = PW'(energy_r);
  assign trial    = g_r | (GRAY_W'(1) << idx_r);
  assign odd      = {trial, 1'b0} - (GRAY_W+1)'(1);
  assign lhs      = (PW'(phi_r) << SAMPLE_BITS) + PW'(plo_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r <= KIND_AMPLITUDE;
    end else if (cfg_write) begin
      kind_r <= cmgp_kind_t'(cfg_preview_kind);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      peak_r <= '0;
    end else if (cmd.peak_upd && (first_r || (energy_r > peak_r))) begin
      peak_r <= energy_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      re_r    <= re_abs;
      im_r    <= im_abs;
      mode_r  <= in_mode;
      first_r <= in_first;
    end
    if (cmd.sq_re) begin
      sq_re_r <= EW'(re_r) * EW'(re_r);
    end
    if (cmd.sq_im) begin
      sq_im_r <= EW'(im_r) * EW'(im_r);
    end
    if (cmd.sum) begin
      energy_r <= sq_re_r + sq_im_r;
    end
    if (cmd.rhs) begin
      if (kind_r == KIND_INTENSITY) begin
        rhs_r <= (energy_w << INT_SH_A) - (energy_w << INT_SH_B);
      end else begin
        rhs_r <= (energy_w << AMP_SH_A) - (energy_w << AMP_SH_B) + (energy_w << AMP_SH_C);
      end
      g_r   <= '0;
      idx_r <= '1;
    end
    if (cmd.trial_sq) begin
      if (kind_r == KIND_INTENSITY) begin
        m_r <= MULT_W'(odd);
      end else begin
        m_r <= MULT_W'(odd) * MULT_W'(odd);
      end
    end
    if (cmd.trial_mlo) begin
      plo_r <= HW'(m_r) * HW'(peak_r[SAMPLE_BITS-1:0]);
    end
    if (cmd.trial_mhi) begin
      phi_r <= HW'(m_r) * HW'(peak_r[EW-1:SAMPLE_BITS]);
    end
    if (cmd.trial_cmp) begin
      if (lhs <= rhs_r) begin
        g_r <= trial;
      end
      idx_r <= idx_r - LEVEL_IDX_W'(1);
    end
    if (cmd.load_out) begin
      gray_r <= g_r;
    end
  end

  assign status.render    = (cmgp_mode_t'(mode_r) == MODE_RENDER);
  assign status.peak_zero = (peak_r == '0);
  assign status.last_step = (idx_r == '0);
  assign out_gray         = gray_r;

endmodule

`default_nettype wire

### rtl/core/cmgp_ctrl.sv
`default_nettype none

module cmgp_ctrl (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  input  wire cmgp_pkg::cmgp_status_t status,
  output cmgp_pkg::cmgp_cmd_t         cmd
);
  import cmgp_pkg::*;

  cmgp_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        out_free;

  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_valid) state_nxt = S_SQ_RE;
      S_SQ_RE: state_nxt = S_SQ_IM;
      S_SQ_IM: state_nxt = S_SUM;
      S_SUM:   state_nxt = status.render ? S_RHS : S_PEAK;
      S_PEAK:  state_nxt = S_IDLE;
      S_RHS:   state_nxt = status.peak_zero ? S_DONE : S_T_SQ;
      S_T_SQ:  state_nxt = S_T_MLO;
      S_T_MLO: state_nxt = S_T_MHI;
      S_T_MHI: state_nxt = S_T_CMP;
      S_T_CMP: state_nxt = status.last_step ? S_DONE : S_T_SQ;
      S_DONE:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
      end
      S_SQ_RE: cmd.sq_re     = 1'b1;
      S_SQ_IM: cmd.sq_im     = 1'b1;
      S_SUM:   cmd.sum       = 1'b1;
      S_PEAK:  cmd.peak_upd  = 1'b1;
      S_RHS:   cmd.rhs       = 1'b1;
      S_T_SQ:  cmd.trial_sq  = 1'b1;
      S_T_MLO: cmd.trial_mlo = 1'b1;
      S_T_MHI: cmd.trial_mhi = 1'b1;
      S_T_CMP: cmd.trial_cmp = 1'b1;
      S_DONE:  cmd.load_out  = out_free;
      default: cmd = '0;
    endcase
  end

  always_comb begin
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  assign out_valid = out_valid_r;

`ifndef NO_ASSERTIONS
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || !out_stall))
    else $error("Result loaded over a transaction not yet taken.");

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == S_SQ_RE))
    else $error("Accepted transaction did not start the energy computation.");

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("Result appeared without a finished render.");

  a_search_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_T_CMP && status.last_step) |=> (state_r == S_DONE))
    else $error("Level search did not end after its last step.");
`endif

endmodule

`default_nettype wire

### rtl/core/complex_magnitude_gray_preview.sv
// A measure transaction passes through SQ_RE, SQ_IM, SUM and PEAK before the next one
// can be accepted. A render transaction passes through SQ_RE, SQ_IM, SUM, RHS, the
// eight-step level search and DONE, where the result is registered once the output is
// free. Each search step runs through T_SQ, T_MLO, T_MHI and T_CMP. With a zero peak
// the search is skipped. Synchronous active-low reset clears the controller, the output
// valid, the kind register and the peak energy.
`default_nettype none

module complex_magnitude_gray_preview #(
  parameter int SAMPLE_BITS = cmgp_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_write,
  input  wire logic                                cfg_preview_kind,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic                                in_mode,
  input  wire logic                                in_first,
  input  wire logic signed [cmgp_pkg::FIELD_W-1:0] in_real_part,
  input  wire logic signed [cmgp_pkg::FIELD_W-1:0] in_imag_part,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic [cmgp_pkg::GRAY_W-1:0]              out_gray
);
  import cmgp_pkg::*;

  cmgp_cmd_t    cmd;
  cmgp_status_t status;

  cmgp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  cmgp_dp #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_write        (cfg_write),
    .cfg_preview_kind (cfg_preview_kind),
    .in_mode          (in_mode),
    .in_first         (in_first),
    .in_real_part     (in_real_part),
    .in_imag_part     (in_imag_part),
    .cmd              (cmd),
    .status           (status),
    .out_gray         (out_gray)
  );

endmodule

`default_nettype wire
